>>> hw/rtl/prim_minimum_spanning_tree_macros.svh
// Assertion macros used by the checker file of the spanning tree block.
// Depends on nothing; included by bare file name.
`ifndef PRIM_MINIMUM_SPANNING_TREE_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_MACROS_SVH
// Plain implication checked on every clock edge outside reset.
`define PMST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that holds at every edge, reset included.
`define PMST_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hw/rtl/pmst_pkg.sv
// Package for the dense Prim spanning tree block: sizes, types and register map.
// Used by every design module of the block; depends on nothing.
package pmst_pkg;
  localparam int MaxVertices = 64;
  localparam int WeightBits  = 32;
  localparam int VertBits    = $clog2(MaxVertices);
  localparam int CountBits   = 7;
  localparam int MatBits     = 2 * VertBits;
  localparam logic [WeightBits-1:0] NoEdge = '1;
  localparam logic [0:0] RegVertexCount = 1'b0;

  typedef logic [WeightBits-1:0] weight_t;
  typedef logic [VertBits-1:0]   vert_t;

  // Control from the sequencer to the row of cells.
  typedef struct packed {
    logic    init;     // start a run: key infinite (zero for vertex 0), tree flag only from add
    logic    upd;      // relax with row weights below
    vert_t   upd_src;  // vertex just added
    logic    add;      // mark one vertex as in tree
    vert_t   add_idx;
  } cell_ctl_t;
endpackage

>>> hw/rtl/prim_minimum_spanning_tree.sv
// Top level of the dense Prim spanning tree block: command port, register
// port and the sequencer. Depends on pmst_pkg, pmst_matrix and pmst_chain.
//
//  Channel   Handshake              Payload
//  in_       start & !busy          in_source_vertex, in_dest_vertex, in_edge_weight,
//                                   in_both_ways, in_last_edge
//  out_      out_valid              out_parent_vertex, out_child_vertex,
//                                   out_parent_found, out_last_pair
//  cfg_      psel&penable&pwrite    vertex_count at address 0
//
// An edge keeps busy high while it reads its cell, compares and writes, then does the
// reverse cell likewise, so a new edge is taken only after busy falls again.
// A last edge adds a set-up step and up to n rounds (row read, relax, segment
// register, fold, pick), then n-1 results and a clearing sweep of every row.
// After reset the same sweep runs with busy high.
// Results cannot be stalled.
module prim_minimum_spanning_tree (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_source_vertex,
  input  logic [5:0]  in_dest_vertex,
  input  logic [31:0] in_edge_weight,
  input  logic        in_both_ways,
  input  logic        in_last_edge,
  output logic        out_valid,
  output logic [5:0]  out_parent_vertex,
  output logic [5:0]  out_child_vertex,
  output logic        out_parent_found,
  output logic        out_last_pair,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_WR1, S_RD2, S_WR2,
    S_INIT, S_PICK0, S_PICK1, S_PICK2, S_PICK3, S_RELAX, S_OUT
  } state_t;

  localparam int CB = pmst_pkg::CountBits;
  localparam int VB = pmst_pkg::VertBits;

  state_t            state_r;
  logic [CB-1:0]     cnt_r;
  logic [CB-1:0]     n_r;
  logic [VB-1:0]     clr_r;
  logic [VB-1:0]     s_r, d_r, cur_r;
  pmst_pkg::weight_t w_r;
  logic              both_r, last_r, ok_r;
  logic [CB-1:0]     round_r;
  logic [VB-1:0]     src_r;

  logic              we, row_we;
  logic [VB-1:0]     wr_row, wr_col, rd_row;
  pmst_pkg::weight_t rd_data [pmst_pkg::MaxVertices];
  pmst_pkg::cell_ctl_t ctl;
  pmst_pkg::vert_t   min_idx;
  logic              min_ok;
  pmst_pkg::vert_t   rd_parent;
  logic              rd_found;
  logic [CB-1:0]     n_eff;
  logic              wr_cfg;

  assign pready = 1'b1;
  assign prdata = {{(32-CB){1'b0}}, cnt_r};
  assign wr_cfg = psel && penable && pwrite &&
                  paddr == pmst_pkg::RegVertexCount;
  assign busy   = state_r != S_IDLE;

  always_comb begin
    if (cnt_r == '0) n_eff = CB'(1);
    else if (cnt_r > CB'(pmst_pkg::MaxVertices)) n_eff = CB'(pmst_pkg::MaxVertices);
    else n_eff = cnt_r;
  end

  always_comb begin
    we     = 1'b0;
    row_we = state_r == S_CLEAR;
    wr_row = s_r;
    wr_col = d_r;
    rd_row = s_r;
    unique case (state_r)
      S_WR1: begin
        we = ok_r && w_r < rd_data[d_r];
      end
      S_RD2: rd_row = d_r;
      S_WR2: begin
        rd_row = d_r;
        wr_row = d_r;
        wr_col = s_r;
        we = ok_r && both_r && w_r < rd_data[s_r];
      end
      S_PICK0, S_PICK1, S_PICK2, S_PICK3, S_RELAX: rd_row = src_r;
      default: ;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.init    = state_r == S_INIT;
    ctl.upd     = state_r == S_PICK1;
    ctl.upd_src = src_r;
    ctl.add     = state_r == S_INIT;
    ctl.add_idx = '0;
  end

  pmst_matrix u_matrix (
    .clk, .we, .wr_row, .wr_col, .wr_data(w_r),
    .row_we, .row_addr(clr_r), .rd_row, .rd_data
  );

  // The picked vertex is added on the relax step through a second control
  // word: init adds vertex 0, later picks add via S_RELAX below.
  pmst_pkg::cell_ctl_t ctl2;
  always_comb begin
    ctl2 = ctl;
    if (state_r == S_RELAX) begin
      ctl2.add     = min_ok;
      ctl2.add_idx = min_idx;
    end
  end

  pmst_chain u_chain (
    .clk, .rst_n, .count(n_r), .ctl(ctl2), .row_w(rd_data),
    .min_idx, .min_ok,
    .rd_idx(cur_r), .rd_parent, .rd_found
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      cnt_r     <= CB'(1);
    end else begin
      out_valid <= state_r == S_OUT;
      if (wr_cfg) cnt_r <= pwdata[CB-1:0];
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          s_r    <= in_source_vertex;
          d_r    <= in_dest_vertex;
          w_r    <= in_edge_weight;
          both_r <= in_both_ways;
          last_r <= in_last_edge;
          n_r    <= n_eff;
          ok_r   <= {1'b0, in_source_vertex} < n_eff && {1'b0, in_dest_vertex} < n_eff;
          state_r <= S_RD1;
        end
        S_RD1: state_r <= S_WR1;
        S_WR1: state_r <= S_RD2;
        S_RD2: state_r <= S_WR2;
        S_WR2: state_r <= last_r ? S_INIT : S_IDLE;
        S_INIT: begin
          src_r   <= '0;
          round_r <= CB'(1);
          state_r <= S_PICK0;
        end
        // The row of the newest tree vertex is read, relaxed into the cells,
        // and the minimum then runs through the segment and fold registers.
        S_PICK0: state_r <= S_PICK1;
        S_PICK1: state_r <= S_PICK2;
        S_PICK2: state_r <= S_PICK3;
        S_PICK3: state_r <= S_RELAX;
        S_RELAX: begin
          if (!min_ok || round_r >= n_r) begin
            cur_r   <= VB'(1);
            state_r <= (n_r == CB'(1)) ? S_CLEAR : S_OUT;
            clr_r   <= '0;
          end else begin
            src_r   <= min_idx;
            round_r <= round_r + 1'b1;
            state_r <= S_PICK0;
          end
        end
        S_OUT: begin
          out_child_vertex  <= cur_r;
          out_parent_vertex <= rd_found ? rd_parent : '0;
          out_parent_found  <= rd_found;
          out_last_pair     <= {1'b0, cur_r} + 1'b1 == n_r;
          cur_r <= cur_r + 1'b1;
          if ({1'b0, cur_r} + 1'b1 == n_r) begin
            clr_r   <= '0;
            state_r <= S_CLEAR;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/pmst_cell.sv
// One vertex cell: holds key, tree flag and parent, and passes the running
// minimum to the next cell of the chain. Depends on pmst_pkg.
module pmst_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pmst_pkg::vert_t     my_idx,
  input  logic                active,
  input  pmst_pkg::cell_ctl_t ctl,
  input  pmst_pkg::weight_t   row_w,
  input  pmst_pkg::weight_t   min_in_key,
  input  pmst_pkg::vert_t     min_in_idx,
  input  logic                min_in_ok,
  output pmst_pkg::weight_t   min_out_key,
  output pmst_pkg::vert_t     min_out_idx,
  output logic                min_out_ok,
  output pmst_pkg::vert_t     parent,
  output logic                found
);
  pmst_pkg::weight_t key_r;
  logic              tree_r;
  pmst_pkg::vert_t   par_r;
  logic              fnd_r;
  logic              cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_r <= 1'b0;
      fnd_r  <= 1'b0;
    end else if (ctl.init) begin
      key_r  <= (my_idx == '0) ? '0 : pmst_pkg::NoEdge;
      tree_r <= ctl.add && ctl.add_idx == my_idx;
      fnd_r  <= 1'b0;
    end else begin
      if (ctl.add && ctl.add_idx == my_idx) tree_r <= 1'b1;
      if (ctl.upd && !tree_r && row_w < key_r) begin
        key_r <= row_w;
        par_r <= ctl.upd_src;
        fnd_r <= 1'b1;
      end
    end
  end

  // Strictly smaller wins, so the lowest index keeps a tie.
  assign cand = active && !tree_r && key_r < pmst_pkg::NoEdge &&
                (!min_in_ok || key_r < min_in_key);
  assign min_out_key = cand ? key_r  : min_in_key;
  assign min_out_idx = cand ? my_idx : min_in_idx;
  assign min_out_ok  = cand || min_in_ok;
  assign parent      = par_r;
  assign found       = fnd_r;
endmodule

>>> hw/rtl/pmst_chain.sv
// Row of vertex cells with the minimum search carried along the chain in
// registered segments of eight cells. Depends on pmst_pkg and pmst_cell.
module pmst_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [pmst_pkg::CountBits-1:0] count,
  input  pmst_pkg::cell_ctl_t ctl,
  input  pmst_pkg::weight_t   row_w [pmst_pkg::MaxVertices],
  output pmst_pkg::vert_t     min_idx,
  output logic                min_ok,
  input  pmst_pkg::vert_t     rd_idx,
  output pmst_pkg::vert_t     rd_parent,
  output logic                rd_found
);
  localparam int Seg  = 8;
  localparam int NSeg = (pmst_pkg::MaxVertices + Seg - 1) / Seg;

  pmst_pkg::weight_t ck [pmst_pkg::MaxVertices+1];
  pmst_pkg::vert_t   ci [pmst_pkg::MaxVertices+1];
  logic              co [pmst_pkg::MaxVertices+1];
  pmst_pkg::weight_t sk_r [NSeg];
  pmst_pkg::vert_t   si_r [NSeg];
  logic              so_r [NSeg];
  pmst_pkg::vert_t   par  [pmst_pkg::MaxVertices];
  logic              fnd  [pmst_pkg::MaxVertices];

  assign ck[0] = pmst_pkg::NoEdge;
  assign ci[0] = '0;
  assign co[0] = 1'b0;

  // Each segment's local minimum is registered; the segments then merge
  // through a short registered fold below.
  for (genvar g = 0; g < pmst_pkg::MaxVertices; g++) begin : g_cell
    pmst_pkg::weight_t ik;
    pmst_pkg::vert_t   ii;
    logic              io;
    if (g % Seg == 0) begin : g_head
      assign ik = pmst_pkg::NoEdge;
      assign ii = '0;
      assign io = 1'b0;
    end else begin : g_link
      assign ik = ck[g];
      assign ii = ci[g];
      assign io = co[g];
    end
    pmst_cell u_cell (
      .clk, .rst_n,
      .my_idx(pmst_pkg::VertBits'(g)),
      .active(pmst_pkg::CountBits'(g) < count),
      .ctl, .row_w(row_w[g]),
      .min_in_key(ik), .min_in_idx(ii), .min_in_ok(io),
      .min_out_key(ck[g+1]), .min_out_idx(ci[g+1]), .min_out_ok(co[g+1]),
      .parent(par[g]), .found(fnd[g])
    );
  end

  for (genvar s = 0; s < NSeg; s++) begin : g_seg
    localparam int Last = ((s + 1) * Seg < pmst_pkg::MaxVertices) ?
                          (s + 1) * Seg : pmst_pkg::MaxVertices;
    always_ff @(posedge clk) begin
      sk_r[s] <= ck[Last];
      si_r[s] <= ci[Last];
      so_r[s] <= co[Last];
    end
  end

  always_ff @(posedge clk) begin
    pmst_pkg::weight_t k;
    pmst_pkg::vert_t   i;
    logic              o;
    k = pmst_pkg::NoEdge;
    i = '0;
    o = 1'b0;
    for (int s = 0; s < NSeg; s++) begin
      if (so_r[s] && (!o || sk_r[s] < k)) begin
        k = sk_r[s];
        i = si_r[s];
        o = 1'b1;
      end
    end
    min_idx <= i;
    min_ok  <= o;
  end

  assign rd_parent = par[rd_idx];
  assign rd_found  = fnd[rd_idx];
endmodule

>>> hw/rtl/pmst_matrix.sv
// Weight matrix memory: 64 banks, one per column, so a whole row is read at once.
// Cleared by a row sweep after each run and after reset. Depends on pmst_pkg.
module pmst_matrix (
  input  logic                 clk,
  input  logic                 we,
  input  pmst_pkg::vert_t      wr_row,
  input  pmst_pkg::vert_t      wr_col,
  input  pmst_pkg::weight_t    wr_data,
  input  logic                 row_we,
  input  pmst_pkg::vert_t      row_addr,
  input  pmst_pkg::vert_t      rd_row,
  output pmst_pkg::weight_t    rd_data [pmst_pkg::MaxVertices]
);
  for (genvar c = 0; c < pmst_pkg::MaxVertices; c++) begin : g_bank
    pmst_pkg::weight_t mem [pmst_pkg::MaxVertices];
    always_ff @(posedge clk) begin
      if (row_we) mem[row_addr] <= pmst_pkg::NoEdge;
      else if (we && wr_col == pmst_pkg::VertBits'(c)) mem[wr_row] <= wr_data;
      rd_data[c] <= mem[rd_row];
    end
  end
endmodule

>>> hw/rtl/pmst_checker.sv
// Port-level checker for the spanning tree block, bound to the top level.
// Depends on the macro header.
`include "prim_minimum_spanning_tree_macros.svh"
module pmst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic [5:0] out_child_vertex,
  input logic       out_parent_found,
  input logic [5:0] out_parent_vertex,
  input logic       pready
);
  `PMST_ASSERT(a_out_busy, clk, rst_n, out_valid |-> busy, "result beat while idle")
  `PMST_ASSERT(a_child_nz, clk, rst_n, out_valid |-> out_child_vertex != 6'd0, "child zero")
  `PMST_ASSERT(a_unfound, clk, rst_n, (out_valid && !out_parent_found) |-> out_parent_vertex == 6'd0, "parent set when unreached")
  `PMST_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")
endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (
  .clk, .rst_n, .busy, .out_valid, .out_child_vertex,
  .out_parent_found, .out_parent_vertex, .pready
);
